// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers for the design files; arps_fifo includes them.
// Each macro expands to a clocked concurrent assertion with async reset disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ARPS_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ARPS_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ARPS_ASSERT(lbl, clk, rst_n, prop, msg)
`define ARPS_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// File: design/arps_pkg.sv
// ----------------------------------------------------------------------------
// arps_pkg
// Types and constants shared by the antialiased ring pixel shader.
// ----------------------------------------------------------------------------
`default_nettype none

package arps_pkg;

	localparam int PIX_W          = 12;
	localparam int COLOR_W        = 32;
	localparam int DIST_W         = 36;
	localparam int SCALE_W        = 32;
	localparam int COORD_BITS_DEF = 12;
	localparam int CFG_IDX_W      = 4;
	localparam int CFG_DATA_W     = 64;
	localparam int Q16_W          = 17;
	localparam logic [Q16_W-1:0] ONE_Q16 = 17'h10000;

	// Queue between front and back; power of two
	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CENTER_X      = 4'd0,
		REG_CENTER_Y      = 4'd1,
		REG_INNER_DIST_SQ = 4'd2,
		REG_FADE_START_SQ = 4'd3,
		REG_OUTER_DIST_SQ = 4'd4,
		REG_COLOUR_SCALE  = 4'd5,
		REG_FADE_SCALE    = 4'd6,
		REG_COLOUR_PAIR   = 4'd7
	} reg_idx_t;

	typedef struct packed {
		logic signed [15:0]  center_x;
		logic signed [15:0]  center_y;
		logic [DIST_W-1:0]   inner_dist_sq;
		logic [DIST_W-1:0]   fade_start_sq;
		logic [DIST_W-1:0]   outer_dist_sq;
		logic [SCALE_W-1:0]  colour_scale;
		logic [SCALE_W-1:0]  fade_scale;
		logic [CFG_DATA_W-1:0] colour_pair;
	} cfg_t;

	typedef enum logic [1:0] {
		CLS_OUTSIDE = 2'd0,
		CLS_SOLID   = 2'd1,
		CLS_RING    = 2'd2
	} cls_t;

	// Classified pixel handed from front to back
	typedef struct packed {
		cls_t               cls;
		logic               fade;
		logic               chi;
		logic [31:0]        cdiff;
		logic               fhi;
		logic [31:0]        fdiff;
		logic [COLOR_W-1:0] dest;
	} job_t;

endpackage

`default_nettype wire

// File: design/arps_in_if.sv
// ----------------------------------------------------------------------------
// arps_in_if
// Pixel input channel: coordinate and destination pixel.
// ----------------------------------------------------------------------------
`default_nettype none

interface arps_in_if;
	logic                         valid;
	logic                         ready;
	logic [arps_pkg::PIX_W-1:0]   pixel_x;
	logic [arps_pkg::PIX_W-1:0]   pixel_y;
	logic [arps_pkg::COLOR_W-1:0] dest_pixel;

	modport source(output valid, pixel_x, pixel_y, dest_pixel, input ready);
	modport sink(input valid, pixel_x, pixel_y, dest_pixel, output ready);
endinterface

`default_nettype wire

// File: design/arps_out_if.sv
// ----------------------------------------------------------------------------
// arps_out_if
// Result channel: blended pixel and its write flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface arps_out_if;
	logic                         valid;
	logic                         ready;
	logic [arps_pkg::COLOR_W-1:0] out_pixel;
	logic                         write_enable;

	modport source(output valid, out_pixel, write_enable, input ready);
	modport sink(input valid, out_pixel, write_enable, output ready);
endinterface

`default_nettype wire

// File: design/arps_front.sv
// ----------------------------------------------------------------------------
// arps_front
// Accepts pixels, measures squared distance and classifies against the radii.
// ----------------------------------------------------------------------------
`default_nettype none

module arps_front #(
	parameter int COORD_BITS = arps_pkg::COORD_BITS_DEF
) (
	input  wire                             clk,
	input  wire                             arst_n,
	arps_in_if.sink                         in_ch,
	input  arps_pkg::cfg_t                  cfg,
	input  wire [arps_pkg::FIFO_CNT_W-1:0]  fifo_count,
	output logic                            push,
	output arps_pkg::job_t                  job
);

	localparam int MAG_W = ((COORD_BITS + 4 > 15) ? COORD_BITS + 4 : 15) + 1;
	localparam int SX_W  = MAG_W + 1;
	localparam int SQ_W  = 2 * MAG_W;
	localparam int D_W   = SQ_W + 1;
	localparam int CMP_W = (D_W > arps_pkg::DIST_W) ? D_W : arps_pkg::DIST_W;

	logic                          v_s1, v_s2, v_s3;
	logic signed [SX_W-1:0]        dx_s1, dy_s1;
	logic [arps_pkg::COLOR_W-1:0]  dest_s1, dest_s2;
	logic [SQ_W-1:0]               sqx_s2, sqy_s2;
	arps_pkg::job_t                job_s3;

	logic [15:0]                   px_ext, py_ext;
	logic [COORD_BITS-1:0]         px, py;
	logic signed [2*SX_W-1:0]      prod_x, prod_y;
	logic [CMP_W-1:0]              d_ext, cdiff, fdiff;
	logic [arps_pkg::FIFO_CNT_W:0] occupancy;
	logic                          accept;

	// Credit check: everything in flight must fit in the queue
	assign occupancy   = (arps_pkg::FIFO_CNT_W+1)'(fifo_count)
		+ (arps_pkg::FIFO_CNT_W+1)'(v_s1) + (arps_pkg::FIFO_CNT_W+1)'(v_s2)
		+ (arps_pkg::FIFO_CNT_W+1)'(v_s3);
	assign in_ch.ready = occupancy < (arps_pkg::FIFO_CNT_W+1)'(arps_pkg::FIFO_DEPTH);
	assign accept      = in_ch.valid && in_ch.ready;

	assign px_ext = 16'(in_ch.pixel_x);
	assign py_ext = 16'(in_ch.pixel_y);
	assign px     = px_ext[COORD_BITS-1:0];
	assign py     = py_ext[COORD_BITS-1:0];

	assign prod_x = dx_s1 * dx_s1;
	assign prod_y = dy_s1 * dy_s1;

	// Distance and differences against the radii
	always_comb begin
		d_ext = CMP_W'(D_W'(sqx_s2) + D_W'(sqy_s2));
		cdiff = d_ext - CMP_W'(cfg.inner_dist_sq);
		fdiff = d_ext - CMP_W'(cfg.fade_start_sq);
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Datapath stages
	always_ff @(posedge clk) begin
		dx_s1   <= $signed(SX_W'({px, 4'b0000})) - SX_W'(cfg.center_x);
		dy_s1   <= $signed(SX_W'({py, 4'b0000})) - SX_W'(cfg.center_y);
		dest_s1 <= in_ch.dest_pixel;

		sqx_s2  <= prod_x[SQ_W-1:0];
		sqy_s2  <= prod_y[SQ_W-1:0];
		dest_s2 <= dest_s1;

		job_s3.dest  <= dest_s2;
		job_s3.cdiff <= cdiff[31:0];
		job_s3.chi   <= |cdiff[CMP_W-1:32];
		job_s3.fdiff <= fdiff[31:0];
		job_s3.fhi   <= |fdiff[CMP_W-1:32];
		job_s3.fade  <= d_ext > CMP_W'(cfg.fade_start_sq);
		priority if (d_ext <= CMP_W'(cfg.inner_dist_sq))
			job_s3.cls <= arps_pkg::CLS_SOLID;
		else if (d_ext <= CMP_W'(cfg.outer_dist_sq))
			job_s3.cls <= arps_pkg::CLS_RING;
		else
			job_s3.cls <= arps_pkg::CLS_OUTSIDE;
	end

	assign push = v_s3;
	assign job  = job_s3;

endmodule

`default_nettype wire

// File: design/arps_fifo.sv
// ----------------------------------------------------------------------------
// arps_fifo
// Short queue decoupling the classifier from the shading pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module arps_fifo (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             push,
	input  arps_pkg::job_t                  wr_job,
	input  wire                             pop,
	output arps_pkg::job_t                  rd_job,
	output logic                            not_empty,
	output logic [arps_pkg::FIFO_CNT_W-1:0] count
);

	arps_pkg::job_t                   mem [arps_pkg::FIFO_DEPTH];
	logic [arps_pkg::FIFO_PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [arps_pkg::FIFO_CNT_W-1:0]  count_q;

	// Storage
	always_ff @(posedge clk) begin
		if (push)
			mem[wr_ptr_q] <= wr_job;
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + arps_pkg::FIFO_CNT_W'(push) - arps_pkg::FIFO_CNT_W'(pop);
		end
	end

	assign rd_job    = mem[rd_ptr_q];
	assign not_empty = count_q != '0;
	assign count     = count_q;

	`ARPS_ASSERT_NEVER(a_no_overflow, clk, arst_n, push && !pop && count_q == arps_pkg::FIFO_CNT_W'(arps_pkg::FIFO_DEPTH), "queue overflow")
	`ARPS_ASSERT_NEVER(a_no_underflow, clk, arst_n, pop && count_q == '0, "queue underflow")
	`ARPS_ASSERT(a_idle_hold, clk, arst_n, (!push && !pop) |=> $stable(count_q), "fill level moved while idle")

endmodule

`default_nettype wire

// File: design/arps_back.sv
// ----------------------------------------------------------------------------
// arps_back
// Gradient weights, colour lerp, alpha fade and blend over the destination.
// ----------------------------------------------------------------------------
`default_nettype none

module arps_back (
	input  wire            clk,
	input  wire            arst_n,
	input  arps_pkg::cfg_t cfg,
	input  arps_pkg::job_t head,
	input  wire            not_empty,
	output logic           pop,
	arps_out_if.source     out_ch
);

	localparam int QW = arps_pkg::Q16_W;
	localparam logic [QW-1:0] ONE = arps_pkg::ONE_Q16;

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, out_v_q;

	// Stage 1: weight products
	arps_pkg::cls_t cls_s1, cls_s2, cls_s3, cls_s4;
	logic [31:0]    dest_s1, dest_s2, dest_s3;
	logic [63:0]    pc_s1, pf_s1;
	logic           czero_s1, chi_s1, fzero_s1, fhi_s1, fade_s1;
	// Stage 2: saturated weights
	logic [QW-1:0]  t_s2, f_s2;
	// Stage 3: shaded source
	logic [7:0]     src_s3 [3];
	logic [7:0]     a_s3;
	// Stage 4: blend sums
	logic [15:0]    sum_s4 [4];
	// Output
	logic [31:0]    pix_q;
	logic           we_q;

	logic [QW-1:0]     t_n, f_n, one_m_t;
	logic [24:0]       raw [4];
	logic signed [26:0] araw;
	logic [7:0]        c0 [4];
	logic [7:0]        c1 [4];
	logic [7:0]        src_n [3];
	logic [7:0]        a_n;
	logic [7:0]        dc [4];
	logic [7:0]        sc [4];
	logic [7:0]        inv_a;
	logic [15:0]       sum_n [4];
	logic [32:0]       quot [4];
	logic [31:0]       pix_n;

	assign en  = !out_v_q || out_ch.ready;
	assign pop = en && not_empty;

	// Saturating weight from the registered product
	always_comb begin
		priority if (czero_s1)
			t_n = '0;
		else if (chi_s1 || pc_s1[63:16] > 48'(ONE))
			t_n = ONE;
		else
			t_n = pc_s1[16+QW-1:16];
		priority if (!fade_s1 || fzero_s1)
			f_n = '0;
		else if (fhi_s1 || pf_s1[63:16] > 48'(ONE))
			f_n = ONE;
		else
			f_n = pf_s1[16+QW-1:16];
	end

	// Lerp and alpha fade
	always_comb begin
		one_m_t = ONE - t_s2;
		for (int i = 0; i < 4; i++) begin
			c0[i]  = cfg.colour_pair[8*i +: 8];
			c1[i]  = cfg.colour_pair[32 + 8*i +: 8];
			raw[i] = 25'(c0[i] * one_m_t) + 25'(c1[i] * t_s2);
		end
		araw = 27'(raw[3]) - 27'({f_s2, 8'h00}) + 27'(f_s2);
		if (araw < 0)
			araw = '0;
		for (int i = 0; i < 3; i++)
			src_n[i] = 8'((raw[i] + 25'd32768) >> 16);
		a_n = 8'((araw + 27'sd32768) >>> 16);
		if (cls_s2 == arps_pkg::CLS_SOLID) begin
			for (int i = 0; i < 3; i++)
				src_n[i] = c0[i];
			a_n = c0[3];
		end
	end

	// Straight (non-premultiplied) alpha over sums
	always_comb begin
		inv_a = 8'd255 - a_s3;
		for (int i = 0; i < 3; i++)
			sc[i] = src_s3[i];
		sc[3] = 8'd255;
		for (int i = 0; i < 4; i++) begin
			dc[i]    = dest_s3[8*i +: 8];
			sum_n[i] = 16'(sc[i] * a_s3) + 16'(dc[i] * inv_a) + 16'd127;
		end
	end

	// Divide by 255 through the reciprocal 32897 / 2^23
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			quot[i]         = 33'(sum_s4[i]) * 33'd32897;
			pix_n[8*i +: 8] = quot[i][30:23];
		end
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			out_v_q <= 1'b0;
		end else if (en) begin
			v_s1    <= not_empty;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			v_s4    <= v_s3;
			out_v_q <= v_s4;
		end
	end

	// Datapath stages
	always_ff @(posedge clk) begin
		if (en) begin
			cls_s1   <= head.cls;
			dest_s1  <= head.dest;
			fade_s1  <= head.fade;
			pc_s1    <= 64'(head.cdiff) * 64'(cfg.colour_scale);
			pf_s1    <= 64'(head.fdiff) * 64'(cfg.fade_scale);
			czero_s1 <= cfg.colour_scale == '0;
			fzero_s1 <= cfg.fade_scale == '0;
			chi_s1   <= head.chi;
			fhi_s1   <= head.fhi;

			cls_s2  <= cls_s1;
			dest_s2 <= dest_s1;
			t_s2    <= t_n;
			f_s2    <= f_n;

			cls_s3  <= cls_s2;
			dest_s3 <= dest_s2;
			src_s3  <= src_n;
			a_s3    <= a_n;

			cls_s4  <= cls_s3;
			sum_s4  <= sum_n;

			unique case (cls_s4)
				arps_pkg::CLS_SOLID, arps_pkg::CLS_RING: begin
					pix_q <= pix_n;
					we_q  <= 1'b1;
				end
				default: begin
					pix_q <= '0;
					we_q  <= 1'b0;
				end
			endcase
		end
	end

	assign out_ch.valid        = out_v_q;
	assign out_ch.out_pixel    = pix_q;
	assign out_ch.write_enable = we_q;

endmodule

`default_nettype wire

// File: design/antialiased_ring_pixel_shader.sv
// ----------------------------------------------------------------------------
// antialiased_ring_pixel_shader
// Shades and blends one pixel of an antialiased filled circle per word.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one word per pixel: pixel_x, pixel_y and the destination
//   ARGB pixel. out_ch returns one word per input word, in order: the
//   blended pixel and write_enable (low, with a zero pixel, outside the edge).
//   Registers are written through cfg_we/cfg_index/cfg_data; write them
//   only while idle, which the block does not enforce; indexes above the
//   last register are ignored. Throughput is one pixel per clock while
//   out_ch.ready stays high. From accept to out_ch.valid a pixel crosses
//   the three-stage distance/classify front, is written into the queue,
//   then crosses the weight, lerp and blend back end, output register last.
//   The front is paced by credits against the eight-entry queue, so input
//   keeps flowing while out_ch is stalled until the queue is full; the back
//   end and output register hold while out_ch.valid is high and ready low.
//   Reset empties the pipeline; it zeroes config, valid bits and pointers.
// ----------------------------------------------------------------------------
`default_nettype none

module antialiased_ring_pixel_shader #(
	parameter int COORD_BITS = arps_pkg::COORD_BITS_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	arps_in_if.sink                          in_ch,
	arps_out_if.source                       out_ch,
	input  wire                              cfg_we,
	input  wire [arps_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire [arps_pkg::CFG_DATA_W-1:0]   cfg_data
);

	arps_pkg::cfg_t                   cfg_q;
	arps_pkg::job_t                   push_job, head_job;
	logic                             push, pop, not_empty;
	logic [arps_pkg::FIFO_CNT_W-1:0]  fifo_count;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (arps_pkg::reg_idx_t'(cfg_index))
				arps_pkg::REG_CENTER_X:      cfg_q.center_x      <= cfg_data[15:0];
				arps_pkg::REG_CENTER_Y:      cfg_q.center_y      <= cfg_data[15:0];
				arps_pkg::REG_INNER_DIST_SQ: cfg_q.inner_dist_sq <= cfg_data[35:0];
				arps_pkg::REG_FADE_START_SQ: cfg_q.fade_start_sq <= cfg_data[35:0];
				arps_pkg::REG_OUTER_DIST_SQ: cfg_q.outer_dist_sq <= cfg_data[35:0];
				arps_pkg::REG_COLOUR_SCALE:  cfg_q.colour_scale  <= cfg_data[31:0];
				arps_pkg::REG_FADE_SCALE:    cfg_q.fade_scale    <= cfg_data[31:0];
				arps_pkg::REG_COLOUR_PAIR:   cfg_q.colour_pair   <= cfg_data;
				default: ;
			endcase
		end
	end

	arps_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.cfg       (cfg_q),
		.fifo_count(fifo_count),
		.push      (push),
		.job       (push_job)
	);

	arps_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_job   (push_job),
		.pop      (pop),
		.rd_job   (head_job),
		.not_empty(not_empty),
		.count    (fifo_count)
	);

	arps_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.head     (head_job),
		.not_empty(not_empty),
		.pop      (pop),
		.out_ch   (out_ch)
	);

endmodule

`default_nettype wire

// File: sim/arps_ring_checker.sv
// ----------------------------------------------------------------------------
// arps_ring_checker
// Watches the pixel, result and register ports of the ring shader, predicts
// each shaded word from its own copy of the registers and compares in order.
// ----------------------------------------------------------------------------
`default_nettype none

module arps_ring_checker (
	input  wire                              clk,
	input  wire                              arst_n,
	arps_in_if                               in_ch,
	arps_out_if                              out_ch,
	input  wire                              cfg_we,
	input  wire [arps_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire [arps_pkg::CFG_DATA_W-1:0]   cfg_data,
	output int                               fails,
	output int                               pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [arps_pkg::COLOR_W-1:0] pix;
		logic                         we;
	} shade_t;

	arps_pkg::cfg_t regs;
	shade_t         shade_q[$];

	// Saturating Q.16 weight: min((diff * scale) >> 16, 1.0)
	function automatic logic [arps_pkg::Q16_W-1:0] ramp(logic [63:0] diff,
			logic [arps_pkg::SCALE_W-1:0] scale);
		logic [63:0] p;
		if (scale == 0)
			return '0;
		if (diff[63:32] != 0)
			return arps_pkg::ONE_Q16;
		p = (diff * {32'd0, scale}) >> 16;
		return (p > 64'(arps_pkg::ONE_Q16)) ? arps_pkg::ONE_Q16 : p[arps_pkg::Q16_W-1:0];
	endfunction

	function automatic logic [7:0] q16_round(longint raw);
		if (raw < 0)
			raw = 0;
		return 8'((raw + 32768) >>> 16);
	endfunction

	// Classify, shade and blend one pixel against the current registers
	function automatic shade_t shade(logic [arps_pkg::PIX_W-1:0] x,
			logic [arps_pkg::PIX_W-1:0] y, logic [arps_pkg::COLOR_W-1:0] dst);
		longint dx, dy, raw;
		logic [63:0] d;
		logic [31:0] c0, c1;
		logic [7:0] s[4];
		logic [7:0] a;
		logic [arps_pkg::Q16_W-1:0] t, f;
		shade_t r;
		int v, dc;
		dx = longint'({x, 4'b0}) - longint'(regs.center_x);
		dy = longint'({y, 4'b0}) - longint'(regs.center_y);
		d  = 64'(dx * dx + dy * dy);
		c0 = regs.colour_pair[31:0];
		c1 = regs.colour_pair[63:32];
		r  = '0;
		if (d <= 64'(regs.inner_dist_sq)) begin
			for (int i = 0; i < 3; i++)
				s[i] = c0[8*i +: 8];
			a = c0[31:24];
		end else if (d <= 64'(regs.outer_dist_sq)) begin
			t = ramp(d - 64'(regs.inner_dist_sq), regs.colour_scale);
			for (int i = 0; i < 3; i++) begin
				raw = longint'(c0[8*i +: 8]) * (65536 - longint'(t))
					+ longint'(c1[8*i +: 8]) * longint'(t);
				s[i] = q16_round(raw);
			end
			raw = longint'(c0[31:24]) * (65536 - longint'(t)) + longint'(c1[31:24]) * longint'(t);
			// alpha fades out past the fade start
			if (d > 64'(regs.fade_start_sq)) begin
				f = ramp(d - 64'(regs.fade_start_sq), regs.fade_scale);
				raw = raw - longint'(f) * 255;
			end
			a = q16_round(raw);
		end else begin
			return r;
		end
		s[3] = 8'd255;
		for (int i = 0; i < 4; i++) begin
			dc = int'(dst[8*i +: 8]);
			v = (int'(s[i]) * int'(a) + dc * (255 - int'(a)) + 127) / 255;
			r.pix[8*i +: 8] = v[7:0];
		end
		r.we = 1'b1;
		return r;
	endfunction

	// Result comparison, prediction of new words, then register mirror
	always @(posedge clk or negedge arst_n) begin
		shade_t want;
		if (!arst_n) begin
			regs = '0;
			shade_q.delete();
			pending = 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (shade_q.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("unexpected word: pix %h we %b",
							out_ch.out_pixel, out_ch.write_enable);
				end else begin
					want = shade_q.pop_front();
					if (want.pix !== out_ch.out_pixel || want.we !== out_ch.write_enable) begin
						fails++;
						if (fails <= 10)
							$display("mismatch: expected pix %h we %b, got pix %h we %b",
								want.pix, want.we, out_ch.out_pixel, out_ch.write_enable);
					end
				end
			end
			if (in_ch.valid && in_ch.ready)
				shade_q.push_back(shade(in_ch.pixel_x, in_ch.pixel_y, in_ch.dest_pixel));
			if (cfg_we) begin
				case (cfg_index)
					arps_pkg::REG_CENTER_X:
						regs.center_x      = cfg_data[15:0];
					arps_pkg::REG_CENTER_Y:
						regs.center_y      = cfg_data[15:0];
					arps_pkg::REG_INNER_DIST_SQ:
						regs.inner_dist_sq = cfg_data[arps_pkg::DIST_W-1:0];
					arps_pkg::REG_FADE_START_SQ:
						regs.fade_start_sq = cfg_data[arps_pkg::DIST_W-1:0];
					arps_pkg::REG_OUTER_DIST_SQ:
						regs.outer_dist_sq = cfg_data[arps_pkg::DIST_W-1:0];
					arps_pkg::REG_COLOUR_SCALE:
						regs.colour_scale  = cfg_data[arps_pkg::SCALE_W-1:0];
					arps_pkg::REG_FADE_SCALE:
						regs.fade_scale    = cfg_data[arps_pkg::SCALE_W-1:0];
					arps_pkg::REG_COLOUR_PAIR:
						regs.colour_pair   = cfg_data;
					default: ;
				endcase
			end
			pending = shade_q.size();
		end
	end

	initial fails = 0;

endmodule

`default_nettype wire

// File: sim/antialiased_ring_pixel_shader_tb.sv
// ----------------------------------------------------------------------------
// antialiased_ring_pixel_shader_tb
// Drives pixel words and register settings into the ring shader under
// several idle/stall mixes; the checker predicts and compares every word.
// ----------------------------------------------------------------------------
`default_nettype none

module antialiased_ring_pixel_shader_tb;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [arps_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [arps_pkg::CFG_DATA_W-1:0] cfg_data;
	int fails, pending;
	int idle_pct, stall_pct;
	int cycles;
	int ctr_px, ctr_py, rad;

	arps_in_if  in_ch();
	arps_out_if out_ch();

	antialiased_ring_pixel_shader dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	arps_ring_checker chk (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.fails(fails), .pending(pending)
	);

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	// Receiver stalls
	always @(posedge clk)
		out_ch.ready <= ($urandom_range(99) >= stall_pct);

	// Run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > 400000) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Keeps cfg_we high across back-to-back writes; cfg_done lowers it
	task automatic reg_write(arps_pkg::reg_idx_t idx, logic [63:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
	endtask

	task automatic cfg_done();
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_pixel(logic [11:0] x, logic [11:0] y, logic [31:0] dst);
		while ($urandom_range(99) < idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid      <= 1'b1;
		in_ch.pixel_x    <= x;
		in_ch.pixel_y    <= y;
		in_ch.dest_pixel <= dst;
		@(negedge clk);
		while (!in_ch.ready)
			@(negedge clk);
		@(posedge clk);
	endtask

	// Wait for every predicted word, then let the pipeline settle
	task automatic drain();
		in_ch.valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (12) @(posedge clk);
	endtask

	function automatic logic [31:0] recip(logic [63:0] diff);
		logic [63:0] q;
		if (diff == 0)
			return $urandom;
		q = 64'h1_0000_0000 / diff;
		return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
	endfunction

	// Random circle; sometimes wild registers or inconsistent radii
	task automatic rand_circle(bit wild);
		logic [63:0] r16, in_sq, fd_sq, out_sq;
		int cx;
		ctr_px = $urandom_range(2047);
		rad    = $urandom_range(1, 60);
		cx     = ctr_px * 16 + $urandom_range(15);
		r16    = rad * 16;
		in_sq  = (r16 > 24) ? (r16 - $urandom_range(8, 24)) ** 2 : 0;
		fd_sq  = (r16 - 8) ** 2;
		out_sq = (r16 + 8) ** 2;
		if ($urandom_range(9) == 0)
			{in_sq, out_sq} = {out_sq, in_sq};
		reg_write(arps_pkg::REG_CENTER_X, 64'(cx));
		ctr_py = $urandom_range(2047);
		reg_write(arps_pkg::REG_CENTER_Y, 64'(ctr_py * 16 + $urandom_range(15)));
		if (wild) begin
			reg_write(arps_pkg::REG_CENTER_X, {$urandom, $urandom});
			reg_write(arps_pkg::REG_CENTER_Y, {$urandom, $urandom});
			reg_write(arps_pkg::REG_INNER_DIST_SQ, {$urandom, $urandom});
			reg_write(arps_pkg::REG_FADE_START_SQ, {$urandom, $urandom});
			reg_write(arps_pkg::REG_OUTER_DIST_SQ, {$urandom, $urandom});
			reg_write(arps_pkg::REG_COLOUR_SCALE, {$urandom, $urandom});
			reg_write(arps_pkg::REG_FADE_SCALE, {$urandom, $urandom});
		end else begin
			reg_write(arps_pkg::REG_INNER_DIST_SQ, in_sq);
			reg_write(arps_pkg::REG_FADE_START_SQ, fd_sq);
			reg_write(arps_pkg::REG_OUTER_DIST_SQ, out_sq);
			reg_write(arps_pkg::REG_COLOUR_SCALE,
				($urandom_range(7) == 0) ? 64'd0 : 64'(recip(fd_sq - in_sq)));
			reg_write(arps_pkg::REG_FADE_SCALE,
				($urandom_range(7) == 0) ? 64'd0 : 64'(recip(out_sq - fd_sq)));
		end
		reg_write(arps_pkg::REG_COLOUR_PAIR, {$urandom, $urandom});
		cfg_done();
	endtask

	function automatic logic [31:0] rand_dest();
		case ($urandom_range(7))
			0: return 32'h0;
			1: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		logic [11:0] x, y;
		int off;
		cycles       = 0;
		idle_pct     = 0;
		stall_pct    = 0;
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		in_ch.valid  = 1'b0;
		in_ch.pixel_x = '0;
		in_ch.pixel_y = '0;
		in_ch.dest_pixel = '0;
		out_ch.ready = 1'b1;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset registers: the origin is solid, anything else is outside
		send_pixel(12'd0, 12'd0, 32'hFFFF_FFFF);
		send_pixel(12'd1, 12'd0, 32'h1234_5678);
		send_pixel(12'd4095, 12'd4095, 32'hFFFF_FFFF);
		drain();

		// Circle of radius 20 at (100,100): solid, ring, fade band, edge, outside
		reg_write(arps_pkg::REG_CENTER_X, 64'd1600);
		reg_write(arps_pkg::REG_CENTER_Y, 64'd1600);
		reg_write(arps_pkg::REG_INNER_DIST_SQ, 64'd65536);
		reg_write(arps_pkg::REG_FADE_START_SQ, 64'd99856);
		reg_write(arps_pkg::REG_OUTER_DIST_SQ, 64'd104976);
		reg_write(arps_pkg::REG_COLOUR_SCALE, 64'(recip(64'd99856 - 64'd65536)));
		reg_write(arps_pkg::REG_FADE_SCALE, 64'(recip(64'd104976 - 64'd99856)));
		reg_write(arps_pkg::REG_COLOUR_PAIR, 64'h00FF_FF00_FF10_2030);
		reg_write(arps_pkg::reg_idx_t'(4'd9), 64'hFFFF_FFFF_FFFF_FFFF);
		reg_write(arps_pkg::reg_idx_t'(4'd15), 64'h0);
		cfg_done();
		send_pixel(12'd100, 12'd100, 32'h0);
		send_pixel(12'd116, 12'd100, 32'hFFFF_FFFF);
		send_pixel(12'd120, 12'd100, 32'h8080_8080);
		send_pixel(12'd125, 12'd100, 32'hFFFF_FFFF);
		send_pixel(12'd120, 12'd102, 32'h0);
		send_pixel(12'd100, 12'd120, 32'hAA55_AA55);
		send_pixel(12'd121, 12'd100, 32'h0);
		send_pixel(12'd0, 12'd4095, 32'hFFFF_FFFF);
		drain();

		// Extreme registers: signed-limit center, zero inner and fade radii, max outer radius and scales
		reg_write(arps_pkg::REG_CENTER_X, 64'h8000);
		reg_write(arps_pkg::REG_CENTER_Y, 64'h7FFF);
		reg_write(arps_pkg::REG_INNER_DIST_SQ, 64'h0);
		reg_write(arps_pkg::REG_FADE_START_SQ, 64'h0);
		reg_write(arps_pkg::REG_OUTER_DIST_SQ, 64'hF_FFFF_FFFF);
		reg_write(arps_pkg::REG_COLOUR_SCALE, 64'hFFFF_FFFF);
		reg_write(arps_pkg::REG_FADE_SCALE, 64'hFFFF_FFFF);
		reg_write(arps_pkg::REG_COLOUR_PAIR, 64'hFFFF_FFFF_FFFF_FFFF);
		cfg_done();
		send_pixel(12'd4095, 12'd0, 32'h0);
		send_pixel(12'd0, 12'd4095, 32'hFFFF_FFFF);
		send_pixel(12'd4095, 12'd4095, 32'h0);
		drain();

		// Inconsistent radii with zero scales
		reg_write(arps_pkg::REG_CENTER_X, 64'h7FFF);
		reg_write(arps_pkg::REG_INNER_DIST_SQ, 64'hF_FFFF_FFFF);
		reg_write(arps_pkg::REG_FADE_START_SQ, 64'd10);
		reg_write(arps_pkg::REG_OUTER_DIST_SQ, 64'd0);
		reg_write(arps_pkg::REG_COLOUR_SCALE, 64'd0);
		reg_write(arps_pkg::REG_FADE_SCALE, 64'd0);
		reg_write(arps_pkg::REG_COLOUR_PAIR, 64'h0);
		cfg_done();
		send_pixel(12'd2047, 12'd2047, 32'hFFFF_FFFF);
		send_pixel(12'd0, 12'd0, 32'h0);
		drain();

		// Random phases across the idle/stall mixes
		for (int ph = 0; ph < 12; ph++) begin
			case (ph % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 72; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 72; end
				default: begin idle_pct = 27; stall_pct = 27; end
			endcase
			rand_circle(ph % 6 == 5);
			for (int n = 0; n < 140; n++) begin
				if ($urandom_range(4) == 0) begin
					x = $urandom;
					y = $urandom;
				end else begin
					off = $urandom_range(2 * (rad + 2)) - (rad + 2);
					x = 12'(ctr_px + off);
					off = $urandom_range(2 * (rad + 2)) - (rad + 2);
					y = 12'(ctr_py + off);
				end
				send_pixel(x, y, rand_dest());
			end
			drain();
		end

		if (fails == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

`default_nettype wire

// File: filelist.f
+incdir+design
design/arps_pkg.sv
design/arps_in_if.sv
design/arps_out_if.sv
design/arps_front.sv
design/arps_fifo.sv
design/arps_back.sv
design/antialiased_ring_pixel_shader.sv
sim/arps_ring_checker.sv
sim/antialiased_ring_pixel_shader_tb.sv
